[rtl/lpfd_pkg.sv]
// types and constants shared by the length-prefixed frame deframer
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned OUT_DATA_W = 2 * WORD_W + BYTE_W;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [WORD_W-1:0] HDR_BYTES = 32'd8;

  // header positions
  localparam logic [IDX_W-1:0] POS_LEN_FIRST = 3'd0;
  localparam logic [IDX_W-1:0] POS_LEN_LAST  = 3'd3;
  localparam logic [IDX_W-1:0] POS_EVT_FIRST = 3'd4;
  localparam logic [IDX_W-1:0] POS_EVT_LAST  = 3'd7;
  localparam logic [POS_W-1:0] POS_PAYLOAD   = 4'd8;

  // tuser bit positions on the result channel
  localparam int unsigned USER_EMPTY = 0;
  localparam int unsigned USER_ERROR = 1;

  typedef struct packed {
    logic [POS_W-1:0]  hdr_pos;
    logic [WORD_W-1:0] total_len;
    logic [WORD_W-1:0] frame_event;
    logic [WORD_W-1:0] remaining;
  } lpfd_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] event_number;
    logic [WORD_W-1:0] payload_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              empty_frame;
    logic              length_error;
  } lpfd_result_t;

endpackage

[rtl/lpfd_parser.sv]
// header parse and payload tagging for one received byte
`timescale 1ns / 1ps

module lpfd_parser (
  input  lpfd_pkg::lpfd_state_t              state,
  input  logic [lpfd_pkg::BYTE_W-1:0]        rx_byte,
  output lpfd_pkg::lpfd_state_t              state_nxt,
  output logic                               res_valid,
  output lpfd_pkg::lpfd_result_t             res
);
  import lpfd_pkg::*;

  logic              in_payload;
  logic [IDX_W-1:0]  pos;
  logic [WORD_W-1:0] len_asm;
  logic [WORD_W-1:0] evt_asm;
  logic [WORD_W-1:0] plen;
  logic [POS_W-1:0]  pos_inc;

  assign in_payload = (state.hdr_pos >= POS_PAYLOAD) && (state.remaining != '0);
  // stray or finished payload phase restarts the header
  assign pos      = (state.hdr_pos >= POS_PAYLOAD) ? POS_LEN_FIRST : state.hdr_pos[IDX_W-1:0];
  assign pos_inc  = {1'b0, pos} + POS_W'(1);
  assign len_asm  = (pos == POS_LEN_FIRST) ? WORD_W'(rx_byte)
                                           : {state.total_len[WORD_W-BYTE_W-1:0], rx_byte};
  assign evt_asm  = (pos == POS_EVT_FIRST) ? WORD_W'(rx_byte)
                                           : {state.frame_event[WORD_W-BYTE_W-1:0], rx_byte};
  assign plen     = state.total_len - HDR_BYTES;

  always_comb begin
    state_nxt = state;
    res_valid = 1'b0;
    res       = '0;
    if (in_payload) begin
      res_valid          = 1'b1;
      res.event_number   = state.frame_event;
      res.payload_length = plen;
      res.payload_byte   = rx_byte;
      res.frame_last     = (state.remaining == WORD_W'(1));
      state_nxt.remaining = state.remaining - WORD_W'(1);
      state_nxt.hdr_pos   = res.frame_last ? '0 : POS_PAYLOAD;
    end else if (pos <= POS_LEN_LAST) begin
      state_nxt.total_len = len_asm;
      state_nxt.hdr_pos   = pos_inc;
      if ((pos == POS_LEN_LAST) && (len_asm < HDR_BYTES)) begin
        // short length: drop the frame and report
        state_nxt        = '0;
        res_valid        = 1'b1;
        res.frame_last   = 1'b1;
        res.length_error = 1'b1;
      end
    end else begin
      state_nxt.frame_event = evt_asm;
      state_nxt.hdr_pos     = pos_inc;
      if (pos == POS_EVT_LAST) begin
        state_nxt.remaining = plen;
        if (plen == '0) begin
          state_nxt.hdr_pos  = '0;
          res_valid          = 1'b1;
          res.event_number   = evt_asm;
          res.frame_last     = 1'b1;
          res.empty_frame    = 1'b1;
        end else begin
          state_nxt.hdr_pos = POS_PAYLOAD;
        end
      end
    end
  end

endmodule

[rtl/length_prefixed_frame_deframer.sv]
// top level of the length-prefixed frame deframer
`timescale 1ns / 1ps

// Usage
//   in_*  : received byte stream, one byte per transaction in in_tdata.
//   out_* : one transaction per payload byte, tagged with the frame's event
//           number and payload length; tlast marks the final byte of a frame.
//           tuser flags an empty frame (bit 0) or a short declared length
//           (bit 1); both give a single transaction with a zero data byte.
//   Header bytes give no output transaction.
// Timing
//   A byte is held in an input register, parsed by one pass of logic and its
//   result lands in the output register, which drives out_tvalid; a stall
//   on out_tready can hold a byte in the input register before that. One
//   byte per cycle is sustained while out_tready stays high.
// Reset
//   rst_n clears both register stages and the parser, which then expects the
//   first header byte.
// Back-pressure
//   While out_tready is low the output register holds its transaction; the
//   input register takes one more byte, and header bytes keep flowing since
//   they produce nothing. in_tready drops once a held byte needs the output.
module length_prefixed_frame_deframer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lpfd_pkg::BYTE_W-1:0]          in_tdata,   // rx_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // event_number, payload_length, payload_byte
  output logic [lpfd_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,  // frame_last
  output logic [lpfd_pkg::OUT_USER_W-1:0]      out_tuser   // empty_frame, length_error
);
  import lpfd_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  lpfd_state_t       state_r;
  lpfd_state_t       state_nxt;
  logic              res_valid;
  lpfd_result_t      res;
  logic              out_valid_r;
  lpfd_result_t      out_res_r;
  logic              out_free;
  logic              consume;

  lpfd_parser u_parser (
    .state     (state_r),
    .rx_byte   (in_byte_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign consume   = in_valid_r && (!res_valid || out_free);
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (consume) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= consume && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && consume && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.payload_byte, out_res_r.payload_length,
                       out_res_r.event_number};
  assign out_tlast  = out_res_r.frame_last;
  assign out_tuser  = {out_res_r.length_error, out_res_r.empty_frame};

endmodule

[rtl/lpfd_checker.sv]
// port-level checks for the length-prefixed frame deframer
`timescale 1ns / 1ps

module lpfd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [lpfd_pkg::BYTE_W-1:0]          in_tdata,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [lpfd_pkg::OUT_DATA_W-1:0]      out_tdata,
  input logic                                 out_tlast,
  input logic [lpfd_pkg::OUT_USER_W-1:0]      out_tuser
);
  import lpfd_pkg::*;

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tready ^ (^in_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
                                  && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_ERROR] |->
      out_tlast && !out_tuser[USER_EMPTY] && (out_tdata == '0))
    else $error("length error transaction not cleared");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_EMPTY] |->
      out_tlast && (out_tdata[OUT_DATA_W-1:WORD_W] == '0))
    else $error("empty frame transaction carries payload");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);
